// ===== hw/rtl/dcm_pkg.sv =====
`timescale 1ns / 1ps
package dcm_pkg;

    localparam logic [7:0] ARC_TYPE_A   = 8'hF9;
    localparam logic [7:0] ARC_TYPE_B   = 8'hFA;
    localparam logic [7:0] DENS_MASK    = 8'h60;
    localparam logic [6:0] REC_PASS_END = 7'h45;
    localparam logic [6:0] REC_MOD_BEG  = 7'h41;
    localparam logic [6:0] REC_DOS      = 7'h42;
    localparam logic [6:0] REC_SPANS    = 7'h43;
    localparam logic [6:0] REC_MOD_END  = 7'h44;
    localparam logic [6:0] REC_REPEAT   = 7'h46;
    localparam logic [6:0] REC_RAW      = 7'h47;
    localparam logic [10:0] CNT_ENH     = 11'd1040;
    localparam logic [10:0] CNT_STD     = 11'd720;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ARCHIVE  = 3'd1;
    localparam logic [2:0] ERR_ZERO_SEC = 3'd2;
    localparam logic [2:0] ERR_SPAN     = 3'd3;
    localparam logic [2:0] ERR_MOD_END  = 3'd4;
    localparam logic [2:0] ERR_RECORD   = 3'd5;

    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_REC,
        PH_MB_LEN, PH_MB_DATA, PH_DOS, PH_CS_OFF, PH_CS_FILL, PH_CS_RAW,
        PH_ME_OFF, PH_RAW, PH_SEC_LO, PH_SEC_HI
    } t_phase;

    // back-end command
    typedef enum logic [2:0] {
        CMD_WRITE, CMD_FILL, CMD_DOS_FILL, CMD_EMIT, CMD_DONE, CMD_ERROR,
        CMD_WRITE_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [7:0]  addr;
        logic [8:0]  len;
        logic [7:0]  data;
        logic [15:0] sector;
        logic [8:0]  size;
        logic [8:0]  pass_bytes;
        logic [2:0]  code;
        logic [10:0] count;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE, BK_FILL, BK_DOS_RD, BK_DOS_WAIT, BK_DOS_FILL, BK_EMIT, BK_CLEAR
    } t_back_state;

endpackage

// ===== hw/rtl/dcm_ram.sv =====
`timescale 1ns / 1ps
module dcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/dcm_front.sv =====
`timescale 1ns / 1ps
module dcm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_in_byte,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output dcm_pkg::t_cmd o_cmd
);
    import dcm_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_sector, n_sector;
    logic        r_dd, n_dd;
    logic [1:0]  r_dmode, n_dmode;
    logic [8:0]  r_pos, n_pos;
    logic [8:0]  r_rem, n_rem;
    logic        r_fillph, n_fillph;
    logic        r_first, n_first;
    logic        r_flag, n_flag;
    logic        r_final, n_final;
    logic        r_halt, n_halt;

    logic [8:0]  w_sz;
    logic [8:0]  w_b;
    logic [8:0]  w_len;
    logic [9:0]  w_fend;
    logic        w_fire;
    t_cmd        w_cmd;
    logic        w_issue;

    assign w_sz    = r_dd ? 9'd256 : 9'd128;
    assign w_b     = {1'b0, i_in_byte};
    assign o_ready = r_halt || i_cmd_ready;
    assign w_fire  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_sector <= '0;
            r_dd     <= 1'b0;
            r_dmode  <= 2'd0;
            r_pos    <= '0;
            r_rem    <= '0;
            r_fillph <= 1'b0;
            r_first  <= 1'b1;
            r_flag   <= 1'b0;
            r_final  <= 1'b0;
            r_halt   <= 1'b0;
        end else if (w_fire && !r_halt) begin
            r_phase  <= n_phase;
            r_sector <= n_sector;
            r_dd     <= n_dd;
            r_dmode  <= n_dmode;
            r_pos    <= n_pos;
            r_rem    <= n_rem;
            r_fillph <= n_fillph;
            r_first  <= n_first;
            r_flag   <= n_flag;
            r_final  <= n_final;
            r_halt   <= n_halt;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_sector = r_sector;
        n_dd     = r_dd;
        n_dmode  = r_dmode;
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_fillph = r_fillph;
        n_first  = r_first;
        n_flag   = r_flag;
        n_final  = r_final;
        n_halt   = r_halt;
        w_issue  = 1'b0;
        w_len    = '0;
        w_fend   = '0;
        w_cmd    = '0;
        w_cmd.op         = CMD_WRITE;
        w_cmd.sector     = r_sector;
        w_cmd.size       = (r_sector <= 16'd3) ? 9'd128 : w_sz;
        w_cmd.pass_bytes = w_sz;
        w_cmd.addr       = r_pos[7:0];
        w_cmd.data       = i_in_byte;

        unique case (r_phase)
            PH_HDR0: begin
                if (i_in_byte != ARC_TYPE_A && i_in_byte != ARC_TYPE_B) begin
                    w_issue = 1'b1; w_cmd.op = CMD_ERROR; w_cmd.code = ERR_ARCHIVE;
                    n_halt = 1'b1;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                n_dd = (i_in_byte & DENS_MASK) == 8'h20;
                priority case (i_in_byte & DENS_MASK)
                    8'h00:   n_dmode = 2'd0;
                    8'h20:   n_dmode = 2'd1;
                    8'h40:   n_dmode = 2'd2;
                    default: n_dmode = r_dmode;
                endcase
                n_final = i_in_byte[7];
                n_phase = PH_HDR2;
            end
            PH_HDR2, PH_SEC_LO: begin
                n_sector = {8'h00, i_in_byte};
                n_phase  = (r_phase == PH_HDR2) ? PH_HDR3 : PH_SEC_HI;
            end
            PH_HDR3, PH_SEC_HI: begin
                n_sector = {i_in_byte, r_sector[7:0]};
                n_phase  = PH_REC;
            end
            PH_REC: begin
                n_flag = i_in_byte[7];
                if (i_in_byte[6:0] == REC_PASS_END) begin
                    if (r_final) begin
                        w_issue = 1'b1; w_cmd.op = CMD_DONE;
                        w_cmd.count = (r_dmode == 2'd2) ? CNT_ENH : CNT_STD;
                        n_halt = 1'b1;
                    end else begin
                        n_phase = PH_HDR0;
                    end
                end else if (r_sector == 16'd0) begin
                    w_issue = 1'b1; w_cmd.op = CMD_ERROR; w_cmd.code = ERR_ZERO_SEC;
                    n_halt = 1'b1;
                end else begin
                    priority case (i_in_byte[6:0])
                        REC_MOD_BEG: n_phase = PH_MB_LEN;
                        REC_DOS: begin
                            n_pos = 9'd123; n_rem = 9'd5; n_phase = PH_DOS;
                        end
                        REC_SPANS: begin
                            n_pos = '0; n_fillph = 1'b0; n_first = 1'b1;
                            n_phase = PH_CS_OFF;
                        end
                        REC_MOD_END: n_phase = PH_ME_OFF;
                        REC_REPEAT: begin
                            w_issue = 1'b1; w_cmd.op = CMD_EMIT;
                            if (i_in_byte[7]) begin
                                n_sector = r_sector + 16'd1; n_phase = PH_REC;
                            end else begin
                                n_phase = PH_SEC_LO;
                            end
                        end
                        REC_RAW: begin
                            n_pos = '0; n_rem = w_sz; n_phase = PH_RAW;
                        end
                        default: begin
                            w_issue = 1'b1; w_cmd.op = CMD_ERROR; w_cmd.code = ERR_RECORD;
                            n_halt = 1'b1;
                        end
                    endcase
                end
            end
            PH_MB_LEN: begin
                n_pos = w_b; n_rem = w_b + 9'd1; n_phase = PH_MB_DATA;
            end
            PH_MB_DATA, PH_DOS, PH_RAW, PH_CS_RAW: begin
                w_issue = 1'b1;
                n_rem = r_rem - 9'd1;
                n_pos = (r_phase == PH_MB_DATA) ? r_pos - 9'd1 : r_pos + 9'd1;
                if (r_phase == PH_MB_DATA && n_rem == 9'd0) begin
                    n_pos = r_pos;
                end
                if (n_rem == 9'd0) begin
                    if (r_phase == PH_CS_RAW) begin
                        n_fillph = ~r_fillph;
                        if (n_pos >= w_sz) begin
                            w_cmd.op = CMD_WRITE_EMIT;
                        end else begin
                            n_phase = PH_CS_OFF;
                        end
                    end else if (r_phase == PH_DOS) begin
                        w_cmd.op = CMD_DOS_FILL;
                    end else begin
                        w_cmd.op = CMD_WRITE_EMIT;
                    end
                    if (r_phase != PH_CS_RAW || n_pos >= w_sz) begin
                        if (r_flag) begin
                            n_sector = r_sector + 16'd1; n_phase = PH_REC;
                        end else begin
                            n_phase = PH_SEC_LO;
                        end
                    end
                end
            end
            PH_CS_OFF: begin
                if (w_b > w_sz || (w_b < r_pos &&
                        (w_b != 9'd0 || (r_pos != 9'd0 && w_sz != 9'd256)))) begin
                    w_issue = 1'b1; w_cmd.op = CMD_ERROR; w_cmd.code = ERR_SPAN;
                    n_halt = 1'b1;
                end else begin
                    w_len = ((w_b != 9'd0 || r_first) ? w_b : w_sz) - r_pos;
                    n_first = 1'b0;
                    n_rem = w_len;
                    if (r_fillph) begin
                        n_phase = PH_CS_FILL;
                    end else if (w_len != 9'd0) begin
                        n_phase = PH_CS_RAW;
                    end else begin
                        n_fillph = ~r_fillph;
                        if (r_pos >= w_sz) begin
                            w_issue = 1'b1; w_cmd.op = CMD_EMIT;
                            if (r_flag) begin
                                n_sector = r_sector + 16'd1; n_phase = PH_REC;
                            end else begin
                                n_phase = PH_SEC_LO;
                            end
                        end
                    end
                end
            end
            PH_CS_FILL: begin
                w_fend = {1'b0, r_pos} + {1'b0, r_rem};
                n_pos = w_fend[8:0];
                n_fillph = ~r_fillph;
                w_cmd.op = CMD_FILL;
                w_cmd.len = (w_fend > 10'd256) ? 9'd256 - r_pos : r_rem;
                w_issue = (r_pos < 9'd256) && (w_cmd.len != 9'd0);
                if (n_pos >= w_sz) begin
                    w_issue = 1'b1;
                    w_cmd.len = (r_pos < 9'd256) ? w_cmd.len : 9'd0;
                    w_cmd.size = {w_cmd.size[8:1], 1'b1};
                    if (r_flag) begin
                        n_sector = r_sector + 16'd1; n_phase = PH_REC;
                    end else begin
                        n_phase = PH_SEC_LO;
                    end
                end else begin
                    n_phase = PH_CS_OFF;
                end
            end
            PH_ME_OFF: begin
                if (w_b >= w_sz) begin
                    w_issue = 1'b1; w_cmd.op = CMD_ERROR; w_cmd.code = ERR_MOD_END;
                    n_halt = 1'b1;
                end else begin
                    n_pos = w_b; n_rem = w_sz - w_b; n_phase = PH_RAW;
                end
            end
            default: n_phase = PH_HDR0;
        endcase
        o_cmd = w_cmd;
        o_cmd_valid = w_fire && w_issue && !r_halt;
    end
endmodule

// ===== hw/rtl/dcm_back.sv =====
`timescale 1ns / 1ps
module dcm_back #(
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  dcm_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [15:0]   o_sector_number,
    output logic [7:0]    o_byte_offset,
    output logic [63:0]   o_data_word,
    output logic          o_last_word,
    output logic [2:0]    o_error_code,
    output logic [10:0]   o_disk_sector_count,
    output logic [8:0]    o_sector_bytes
);
    import dcm_pkg::*;

    localparam int BW = $clog2(BYTES_PER_RESULT + 1);

    t_back_state r_st, n_st;
    t_cmd        r_cmd, n_cmd;
    logic [8:0]  r_ptr, n_ptr;
    logic [8:0]  r_rd, n_rd;
    logic [BW-1:0] r_got, n_got;
    logic [63:0] r_acc, n_acc;
    logic        r_rdv, n_rdv;
    logic [8:0]  r_woff, n_woff;
    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_secn, n_secn;
    logic [7:0]  r_off, n_off;
    logic [63:0] r_data, n_data;
    logic        r_last, n_last;
    logic [2:0]  r_err, n_err;
    logic [10:0] r_cnt, n_cnt;
    logic [8:0]  r_sb, n_sb;

    logic        w_we;
    logic [7:0]  w_wa, w_wd, w_ra, w_rdata;
    logic        w_emit_after;

    dcm_ram #(.WIDTH(8), .DEPTH(256)) u_buf (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_rdata)
    );

    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_sector_number = r_secn;
    assign o_byte_offset = r_off;
    assign o_data_word = r_data;
    assign o_last_word = r_last;
    assign o_error_code = r_err;
    assign o_disk_sector_count = r_cnt;
    assign o_sector_bytes = r_sb;
    assign o_cmd_ready = (r_st == BK_IDLE) && !(r_ov && !i_ready);
    // odd size flags a fill that ends the record
    assign w_emit_after = r_cmd.size[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_CLEAR;
            r_ov <= 1'b0;
            r_rdv <= 1'b0;
            r_ptr <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_rdv <= n_rdv;
            r_ptr <= n_ptr;
        end
        r_cmd <= n_cmd; r_rd <= n_rd; r_got <= n_got;
        r_acc <= n_acc; r_woff <= n_woff; r_kind <= n_kind; r_secn <= n_secn;
        r_off <= n_off; r_data <= n_data; r_last <= n_last; r_err <= n_err;
        r_cnt <= n_cnt; r_sb <= n_sb;
    end

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_ptr = r_ptr; n_rd = r_rd; n_got = r_got;
        n_acc = r_acc; n_rdv = 1'b0; n_woff = r_woff;
        n_ov = r_ov && !i_ready;
        n_kind = r_kind; n_secn = r_secn; n_off = r_off; n_data = r_data;
        n_last = r_last; n_err = r_err; n_cnt = r_cnt; n_sb = r_sb;
        w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = r_rd[7:0];
        unique case (r_st)
            BK_CLEAR: begin
                w_we = 1'b1; w_wa = r_ptr[7:0]; w_wd = '0;
                n_ptr = r_ptr + 9'd1;
                if (r_ptr == 9'd255) begin
                    n_ptr = '0; n_st = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_cmd = i_cmd;
                    n_cmd.size = {i_cmd.size[8:1], 1'b0};
                    n_ptr = '0; n_rd = '0; n_got = '0; n_acc = '0; n_woff = '0;
                    unique case (i_cmd.op)
                        CMD_WRITE: begin
                            w_we = 1'b1; w_wa = i_cmd.addr; w_wd = i_cmd.data;
                        end
                        CMD_WRITE_EMIT: begin
                            w_we = 1'b1; w_wa = i_cmd.addr; w_wd = i_cmd.data;
                            n_st = BK_EMIT;
                        end
                        CMD_DOS_FILL: begin
                            w_we = 1'b1; w_wa = i_cmd.addr; w_wd = i_cmd.data;
                            n_st = BK_DOS_RD;
                        end
                        CMD_FILL: begin
                            n_cmd.size = i_cmd.size;
                            n_st = BK_FILL;
                        end
                        CMD_EMIT: n_st = BK_EMIT;
                        CMD_DONE, CMD_ERROR: begin
                            n_ov = 1'b1;
                            n_kind = (i_cmd.op == CMD_DONE) ? KIND_DONE : KIND_ERROR;
                            n_secn = '0; n_off = '0; n_data = '0; n_last = 1'b1;
                            n_err = (i_cmd.op == CMD_DONE) ? ERR_NONE : i_cmd.code;
                            n_cnt = i_cmd.count; n_sb = i_cmd.pass_bytes;
                        end
                        default: ;
                    endcase
                end
            end
            BK_FILL: begin
                if (r_ptr < r_cmd.len) begin
                    w_we = 1'b1; w_wa = r_cmd.addr + r_ptr[7:0]; w_wd = r_cmd.data;
                    n_ptr = r_ptr + 9'd1;
                end else begin
                    n_ptr = '0;
                    n_cmd.size = {r_cmd.size[8:1], 1'b0};
                    n_st = w_emit_after ? BK_EMIT : BK_IDLE;
                end
            end
            BK_DOS_RD: begin
                w_ra = 8'd123;
                n_st = BK_DOS_WAIT;
            end
            BK_DOS_WAIT: begin
                n_cmd.data = w_rdata;
                n_st = BK_DOS_FILL;
            end
            BK_DOS_FILL: begin
                w_we = 1'b1; w_wa = r_ptr[7:0]; w_wd = r_cmd.data;
                n_ptr = r_ptr + 9'd1;
                if (r_ptr == 9'd122) begin
                    n_ptr = '0; n_st = BK_EMIT;
                end
            end
            BK_EMIT: begin
                n_rdv = 1'b0;
                if (!r_ov || i_ready) begin
                    if (r_rdv) begin
                        n_acc = r_acc | ({56'd0, w_rdata} << {r_got, 3'b000});
                        n_got = r_got + BW'(1);
                    end
                    if ((r_rdv ? r_got + BW'(1) : r_got) == BW'(BYTES_PER_RESULT)
                        || (r_rdv && r_rd == r_cmd.size)) begin
                        n_ov = 1'b1;
                        n_kind = KIND_DATA; n_secn = r_cmd.sector;
                        n_off = r_woff[7:0];
                        n_data = r_rdv ? r_acc | ({56'd0, w_rdata} << {r_got, 3'b000})
                                       : r_acc;
                        n_last = (r_woff + 9'(BYTES_PER_RESULT)) >= r_cmd.size;
                        n_err = ERR_NONE; n_cnt = '0; n_sb = r_cmd.pass_bytes;
                        n_woff = r_woff + 9'(BYTES_PER_RESULT);
                        n_acc = '0; n_got = '0;
                        if (n_last) begin
                            n_st = BK_IDLE;
                        end
                    end else if (r_rd < r_cmd.size && !r_rdv) begin
                        w_ra = r_rd[7:0];
                        n_rd = r_rd + 9'd1;
                        n_rdv = 1'b1;
                    end
                end else begin
                    n_rdv = r_rdv;
                    w_ra = r_rd[7:0] - 8'd1;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/dcm_disk_archive_decoder_unit.sv =====
`timescale 1ns / 1ps
// Disk-archive decoder. One archive byte is taken per transaction; the front
// parser takes a byte whenever its two-entry command queue has room, so
// bytes keep flowing while the back end works. Byte writes go into the
// sector buffer; a fill span is written one byte at a time, a DOS sector
// copies byte 123 into bytes 0 to 122, and each finished sector is read
// back byte by byte through the single read port and packed into words,
// more slowly while results are held off. After reset the back end clears
// the sector buffer before it runs the first command. Done and error
// results halt the block until reset; further bytes are accepted and
// dropped.
module dcm_disk_archive_decoder_unit #(
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_sector_number,
    output logic [7:0]  o_byte_offset,
    output logic [63:0] o_data_word,
    output logic        o_last_word,
    output logic [2:0]  o_error_code,
    output logic [10:0] o_disk_sector_count,
    output logic [8:0]  o_sector_bytes
);
    import dcm_pkg::*;

    logic w_cv, w_cr;
    t_cmd w_cmd;

    t_cmd        r_q [2];
    logic [1:0]  r_qcnt;
    logic        r_qwp, r_qrp;
    logic        w_bv, w_br, w_push, w_pop;

    assign w_cr   = (r_qcnt != 2'd2);
    assign w_bv   = (r_qcnt != 2'd0);
    assign w_push = w_cv && w_cr;
    assign w_pop  = w_bv && w_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
            r_qwp  <= 1'b0;
            r_qrp  <= 1'b0;
        end else begin
            r_qcnt <= r_qcnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_push) begin
                r_qwp <= ~r_qwp;
            end
            if (w_pop) begin
                r_qrp <= ~r_qrp;
            end
        end
        if (w_push) begin
            r_q[r_qwp] <= w_cmd;
        end
    end

    dcm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_in_byte(i_in_byte), .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    dcm_back #(.BYTES_PER_RESULT(BYTES_PER_RESULT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_bv), .o_cmd_ready(w_br),
        .i_cmd(r_q[r_qrp]), .o_valid(o_valid), .i_ready(i_ready), .o_kind(o_kind),
        .o_sector_number(o_sector_number), .o_byte_offset(o_byte_offset),
        .o_data_word(o_data_word), .o_last_word(o_last_word),
        .o_error_code(o_error_code), .o_disk_sector_count(o_disk_sector_count),
        .o_sector_bytes(o_sector_bytes)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERROR |-> o_last_word) else $error("error not last");
    a_data_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA |-> o_error_code == ERR_NONE)
        else $error("data with code");
    a_cmd_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv |-> w_cr) else $error("command lost");
endmodule

// ===== test/dcm_disk_archive_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
module dcm_disk_archive_decoder_unit_tb;
    import dcm_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sector;
        logic [7:0]  offset;
        logic [63:0] data;
        logic        last;
        logic [2:0]  code;
        logic [10:0] count;
        logic [8:0]  bytes;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_sector_number;
    logic [7:0]  o_byte_offset;
    logic [63:0] o_data_word;
    logic        o_last_word;
    logic [2:0]  o_error_code;
    logic [10:0] o_disk_sector_count;
    logic [8:0]  o_sector_bytes;

    dcm_disk_archive_decoder_unit uut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mirror of the decoder
    logic [7:0]  sec_buf [256];
    t_phase      phase;
    logic [15:0] cur_sec;
    logic        dbl;
    logic [1:0]  dens_mode;
    int          span_pos;
    int          span_rem;
    logic        fill_ph;
    logic        first_sp;
    logic [7:0]  rec_flags;
    logic        last_pass;
    logic        stopped;

    t_word       pending_words[$];
    logic [7:0]  archive[$];
    int          mismatches = 0;
    int          words_seen = 0;
    bit          calm = 0;
    bit          hold_done = 0;

    localparam logic [7:0] DIRECTED [0:28] = '{
        ARC_TYPE_A, 8'h20, 8'h01, 8'h00,
        {1'b1, REC_REPEAT},
        {1'b1, REC_DOS}, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80,
        {1'b0, REC_PASS_END},
        ARC_TYPE_B, 8'h60, 8'h04, 8'h00,
        {1'b1, REC_MOD_END}, 8'h7F, 8'hFF,
        {1'b1, REC_SPANS}, 8'h00, 8'h80, 8'hFF,
        {1'b1, REC_PASS_END},
        ARC_TYPE_A, 8'h00, 8'h00, 8'h00,
        {1'b0, REC_PASS_END}
    };

    task automatic stash_byte(input logic [7:0] b);
        archive.insert(archive.size(), b);
    endtask

    function automatic int pass_len();
        return dbl ? 256 : 128;
    endfunction

    task automatic add_word(input logic [1:0] k, input logic [15:0] s, input logic [7:0] o,
                            input logic [63:0] d, input logic l, input logic [2:0] c,
                            input logic [10:0] n);
        t_word w;
        w = '{k, s, o, d, l, c, n, 9'(pass_len())};
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic halt_with(input logic [2:0] c);
        stopped = 1'b1;
        add_word(KIND_ERROR, 16'd0, 8'd0, 64'd0, 1'b1, c, 11'd0);
    endtask

    task automatic send_sector();
        int size;
        logic [63:0] w;
        size = (cur_sec <= 3) ? 128 : pass_len();
        for (int off = 0; off < size; off += 8) begin
            w = '0;
            for (int i = 0; i < 8; i++) w[8*i +: 8] = sec_buf[(off + i) & 255];
            add_word(KIND_DATA, cur_sec, 8'(off), w, off + 8 >= size, ERR_NONE, 11'd0);
        end
        if (rec_flags[7]) begin
            cur_sec = cur_sec + 16'd1;
            phase = PH_REC;
        end else begin
            phase = PH_SEC_LO;
        end
    endtask

    task automatic close_span();
        fill_ph = ~fill_ph;
        if (span_pos >= pass_len()) send_sector();
        else phase = PH_CS_OFF;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int sz;
        int len;
        logic [6:0] t;
        sz = pass_len();
        t = b[6:0];
        if (!stopped) begin
            case (phase)
                PH_HDR0: begin
                    if (b != ARC_TYPE_A && b != ARC_TYPE_B) halt_with(ERR_ARCHIVE);
                    else phase = PH_HDR1;
                end
                PH_HDR1: begin
                    dbl = (b & DENS_MASK) == 8'h20;
                    if ((b & DENS_MASK) != 8'h60) dens_mode = 2'(b[6:5]);
                    last_pass = b[7];
                    phase = PH_HDR2;
                end
                PH_HDR2: begin
                    cur_sec = {8'd0, b};
                    phase = PH_HDR3;
                end
                PH_HDR3: begin
                    cur_sec[15:8] = b;
                    phase = PH_REC;
                end
                PH_REC: begin
                    rec_flags = b;
                    if (t == REC_PASS_END) begin
                        if (last_pass) begin
                            stopped = 1'b1;
                            add_word(KIND_DONE, 16'd0, 8'd0, 64'd0, 1'b1, ERR_NONE,
                                     dens_mode == 2'd2 ? CNT_ENH : CNT_STD);
                        end else begin
                            phase = PH_HDR0;
                        end
                    end else if (cur_sec == 16'd0) begin
                        halt_with(ERR_ZERO_SEC);
                    end else if (t == REC_MOD_BEG) begin
                        phase = PH_MB_LEN;
                    end else if (t == REC_DOS) begin
                        span_pos = 123;
                        span_rem = 5;
                        phase = PH_DOS;
                    end else if (t == REC_SPANS) begin
                        span_pos = 0;
                        fill_ph = 1'b0;
                        first_sp = 1'b1;
                        phase = PH_CS_OFF;
                    end else if (t == REC_MOD_END) begin
                        phase = PH_ME_OFF;
                    end else if (t == REC_REPEAT) begin
                        send_sector();
                    end else if (t == REC_RAW) begin
                        span_pos = 0;
                        span_rem = sz;
                        phase = PH_RAW;
                    end else begin
                        halt_with(ERR_RECORD);
                    end
                end
                PH_MB_LEN: begin
                    span_pos = b;
                    span_rem = b + 1;
                    phase = PH_MB_DATA;
                end
                PH_MB_DATA: begin
                    sec_buf[span_pos & 255] = b;
                    span_rem--;
                    if (span_rem == 0) send_sector();
                    else span_pos = (span_pos - 1) & 9'h1FF;
                end
                PH_DOS: begin
                    sec_buf[span_pos & 255] = b;
                    span_pos++;
                    span_rem--;
                    if (span_rem == 0) begin
                        for (int i = 0; i < 123; i++) sec_buf[i] = sec_buf[123];
                        send_sector();
                    end
                end
                PH_CS_OFF: begin
                    if (b > sz) begin
                        halt_with(ERR_SPAN);
                    end else if (b < span_pos && (b != 0 || (span_pos != 0 && sz != 256))) begin
                        halt_with(ERR_SPAN);
                    end else begin
                        len = ((b != 0 || first_sp) ? int'(b) : sz) - span_pos;
                        first_sp = 1'b0;
                        span_rem = len;
                        if (fill_ph) phase = PH_CS_FILL;
                        else if (len != 0) phase = PH_CS_RAW;
                        else close_span();
                    end
                end
                PH_CS_FILL: begin
                    for (int i = 0; i < span_rem; i++)
                        if (span_pos + i < 256) sec_buf[span_pos + i] = b;
                    span_pos = span_pos + span_rem;
                    close_span();
                end
                PH_CS_RAW: begin
                    sec_buf[span_pos & 255] = b;
                    span_pos++;
                    span_rem--;
                    if (span_rem == 0) close_span();
                end
                PH_ME_OFF: begin
                    if (b >= sz) begin
                        halt_with(ERR_MOD_END);
                    end else begin
                        span_pos = b;
                        span_rem = sz - b;
                        phase = PH_RAW;
                    end
                end
                PH_RAW: begin
                    sec_buf[span_pos & 255] = b;
                    span_pos++;
                    span_rem--;
                    if (span_rem == 0) send_sector();
                end
                PH_SEC_LO: begin
                    cur_sec = {8'd0, b};
                    phase = PH_SEC_HI;
                end
                PH_SEC_HI: begin
                    cur_sec[15:8] = b;
                    phase = PH_REC;
                end
                default: phase = PH_HDR0;
            endcase
        end
    endtask

    task automatic put_random(input int n);
        repeat (n) stash_byte(8'($urandom));
    endtask

    task automatic put_record(input int sz);
        logic [7:0] f;
        int t, c, e, stop, pos, sec;
        bit first, fl;
        f = ($urandom_range(0, 3) != 0) ? 8'h80 : 8'h00;
        t = $urandom_range(0, 39);
        if (t < 8 || (t >= 38 && sz != 128)) begin
            stash_byte(f | REC_REPEAT);
        end else if (t < 16) begin
            c = $urandom_range(0, 6);
            stash_byte(f | REC_MOD_BEG);
            stash_byte(8'(c));
            put_random(c + 1);
        end else if (t < 22) begin
            stash_byte(f | REC_DOS);
            put_random(5);
        end else if (t < 32) begin
            stash_byte(f | REC_SPANS);
            pos = 0;
            first = 1;
            fl = 0;
            while (pos < sz) begin
                if (first && $urandom_range(0, 3) == 0) e = 0;
                else if (fl) e = ($urandom_range(0, 2) == 0) ? sz : $urandom_range(pos, sz);
                else e = (pos + $urandom_range(0, 4) > sz) ? sz : pos + $urandom_range(0, 4);
                if (first && e == 256) e = 255;
                if (!first && e == 0) e = fl ? sz : 1;
                stash_byte(e == 256 ? 8'd0 : 8'(e));
                stop = e;
                if (fl) stash_byte(8'($urandom));
                else put_random(stop - pos);
                pos = stop;
                first = 0;
                fl = ~fl;
            end
        end else if (t < 38) begin
            c = $urandom_range(sz - 4, sz - 1);
            stash_byte(f | REC_MOD_END);
            stash_byte(8'(c));
            put_random(sz - c);
        end else begin
            stash_byte(f | REC_RAW);
            put_random(sz);
        end
        if (!f[7]) begin
            sec = $urandom_range(1, 1100);
            stash_byte(8'(sec));
            stash_byte(8'(sec >> 8));
        end
    endtask

    task automatic put_pass(input bit fin);
        logic [7:0] info;
        int sec;
        info = {fin, 7'($urandom)};
        sec = $urandom_range(1, 1000);
        stash_byte($urandom_range(0, 1) ? ARC_TYPE_A : ARC_TYPE_B);
        stash_byte(info);
        stash_byte(8'(sec));
        stash_byte(8'(sec >> 8));
        repeat ($urandom_range(2, 6)) put_record((info & DENS_MASK) == 8'h20 ? 256 : 128);
        stash_byte({1'($urandom), REC_PASS_END});
    endtask

    task automatic put_header_sec5();
        stash_byte(ARC_TYPE_A);
        stash_byte(8'h00);
        stash_byte(8'h05);
        stash_byte(8'h00);
    endtask

    task automatic build_archive();
        foreach (DIRECTED[i]) stash_byte(DIRECTED[i]);
        while (archive.size() < 215) put_pass(1'b0);
        case ($urandom_range(0, 5))
            0: stash_byte(8'h10);
            1: begin
                stash_byte(ARC_TYPE_B);
                stash_byte(8'h00);
                stash_byte(8'hFF);
                stash_byte(8'hFF);
                stash_byte({1'b1, REC_REPEAT});
                stash_byte({1'b1, REC_REPEAT});
            end
            2: begin
                put_header_sec5();
                stash_byte({1'b1, REC_SPANS});
                stash_byte(8'h81);
            end
            3: begin
                put_header_sec5();
                stash_byte({1'b1, REC_MOD_END});
                stash_byte(8'h80);
            end
            4: begin
                put_header_sec5();
                stash_byte(8'hD0);
            end
            default: put_pass(1'b1);
        endcase
        put_random(10);
    endtask

    always @(posedge i_clk) begin
        t_word got, want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{o_kind, o_sector_number, o_byte_offset, o_data_word, o_last_word,
                        o_error_code, o_disk_sector_count, o_sector_bytes};
                words_seen++;
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %p", got);
                end else begin
                    want = pending_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (i_valid && o_ready) decode_byte(i_in_byte);
        end
    end

    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && words_seen >= 40) begin
                hold_done = 1;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'd0;
        foreach (sec_buf[i]) sec_buf[i] = 8'd0;
        phase = PH_HDR0;
        cur_sec = 16'd0;
        dbl = 1'b0;
        dens_mode = 2'd0;
        span_pos = 0;
        span_rem = 0;
        fill_ph = 1'b0;
        first_sp = 1'b1;
        rec_flags = 8'd0;
        last_pass = 1'b0;
        stopped = 1'b0;
        build_archive();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < archive.size(); i++) begin
            if (i >= archive.size() - 30) calm = 1;
            if (i == 120) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_words.size() != 0) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_in_byte <= archive[i];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/dcm_pkg.sv
hw/rtl/dcm_ram.sv
hw/rtl/dcm_front.sv
hw/rtl/dcm_back.sv
hw/rtl/dcm_disk_archive_decoder_unit.sv
test/dcm_disk_archive_decoder_unit_tb.sv
